// ===== hw/rtl/vlid_pkg.sv =====
`default_nettype none

package vlid_pkg;

    // accumulator width (8 to 64)
    localparam int VALUE_WIDTH = 32;

    // output and register widths fixed by the interface
    localparam int OUT_WIDTH  = 32;
    localparam int CFG_WIDTH  = 5;
    localparam int IDX_WIDTH  = 2;
    localparam int ZC_WIDTH   = 6;
    localparam int BL_WIDTH   = 5;
    localparam int ADD_WIDTH  = 7;

    // leading-zero counter saturation
    localparam logic [ZC_WIDTH-1:0] ZC_MAX = 6'd63;

    // decode phase codes
    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_GROUP  = 2'd1;
    localparam logic [1:0] PH_TAIL   = 2'd2;

    // configuration register indexes
    localparam logic [IDX_WIDTH-1:0] CFG_GROUP_BITS   = 2'd0;
    localparam logic [IDX_WIDTH-1:0] CFG_TAIL_BITS    = 2'd1;
    localparam logic [IDX_WIDTH-1:0] CFG_CLASSIC_MODE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/variable_length_integer_bit_decoder_unit.sv =====
`default_nettype none

// Generalised Elias-gamma bit decoder. One code bit is taken per word on the
// input channel and every bit is consumed in the cycle it is accepted, so the
// block sustains one bit per clock unless input is stalled; a decoded value
// appears on the output channel in the cycle after the bit that completes it.
// The single output register decouples the channels: input is stalled only
// while that register holds a value that the output side is stalling. The
// accumulator is vlid_pkg::VALUE_WIDTH bits wide and its low 32 bits are
// delivered together with a flag that reports any overflow during the value.
// Group size, tail size and mode may only be changed while the decoder is idle.
module variable_length_integer_bit_decoder_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [vlid_pkg::IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [vlid_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    // input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_code_bit,
    // output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [vlid_pkg::OUT_WIDTH-1:0]       o_decoded_value,
    output logic                                 o_overflow
);

    localparam int VW = vlid_pkg::VALUE_WIDTH;

    // configuration registers
    logic [vlid_pkg::BL_WIDTH-1:0] r_group_bits;
    logic [vlid_pkg::BL_WIDTH-1:0] r_tail_bits;
    logic                          r_classic;

    // decode state
    logic [1:0]                    r_phase,   n_phase;
    logic [VW-1:0]                 r_acc,     n_acc;
    logic [vlid_pkg::ZC_WIDTH-1:0] r_zc,      n_zc;
    logic [vlid_pkg::BL_WIDTH-1:0] r_bl,      n_bl;
    logic                          r_ovf,     n_ovf;

    // output register
    logic                          r_out_valid;
    logic [vlid_pkg::OUT_WIDTH-1:0] r_out_value;
    logic                          r_out_ovf;

    // step datapath
    logic                          in_accept;
    logic [VW-1:0]                 sh_acc;
    logic [vlid_pkg::BL_WIDTH-1:0] bl_dec;
    logic [vlid_pkg::ZC_WIDTH-1:0] zc_dec;
    logic [1:0]                    step_phase;
    logic [vlid_pkg::ZC_WIDTH-1:0] step_zc;
    logic [vlid_pkg::BL_WIDTH-1:0] step_bl;
    logic                          use_shift;
    logic                          add_en;
    logic [vlid_pkg::ADD_WIDTH-1:0] addend;
    logic                          do_tail;
    logic                          do_emit;
    logic                          set_ovf;
    logic [VW:0]                   sum_w;
    logic [VW-1:0]                 acc_new;
    logic                          ovf_new;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    // shifted accumulator and decremented counters
    assign sh_acc = {r_acc[VW-2:0], i_code_bit};
    assign bl_dec = (r_bl != '0) ? r_bl - 1'b1 : r_bl;
    assign zc_dec = (r_zc != '0) ? r_zc - 1'b1 : r_zc;

    // phase decisions
    always_comb begin
        step_phase = r_phase;
        step_zc    = r_zc;
        step_bl    = r_bl;
        use_shift  = 1'b0;
        add_en     = 1'b0;
        addend     = vlid_pkg::ADD_WIDTH'(1);
        do_tail    = 1'b0;
        set_ovf    = 1'b0;
        unique case (r_phase)
            vlid_pkg::PH_GROUP: begin
                use_shift = 1'b1;
                step_bl   = bl_dec;
                if (bl_dec == '0) begin
                    add_en = 1'b1;
                    if (!r_classic) begin
                        step_phase = vlid_pkg::PH_PREFIX;
                    end else if (zc_dec != '0 && r_group_bits != '0) begin
                        step_zc = zc_dec;
                        step_bl = r_group_bits;
                    end else begin
                        // remaining groups are empty: one increment each
                        addend  = vlid_pkg::ADD_WIDTH'(zc_dec) + 1'b1;
                        step_zc = '0;
                        do_tail = 1'b1;
                    end
                end
            end
            vlid_pkg::PH_TAIL: begin
                use_shift = 1'b1;
                step_bl   = bl_dec;
                // emit is raised below when the tail count runs out
            end
            default: begin
                step_phase = vlid_pkg::PH_PREFIX;
                if (!r_classic) begin
                    if (i_code_bit) begin
                        do_tail = 1'b1;
                    end else if (r_group_bits == '0) begin
                        add_en = 1'b1;
                    end else begin
                        step_bl    = r_group_bits;
                        step_phase = vlid_pkg::PH_GROUP;
                    end
                end else if (!i_code_bit) begin
                    if (r_zc >= vlid_pkg::ZC_MAX) begin
                        set_ovf = 1'b1;
                    end else begin
                        step_zc = r_zc + 1'b1;
                    end
                end else if (r_zc == '0) begin
                    do_tail = 1'b1;
                end else if (r_group_bits == '0) begin
                    // all groups empty: accumulator takes the zero count
                    add_en  = 1'b1;
                    addend  = vlid_pkg::ADD_WIDTH'(r_zc);
                    step_zc = '0;
                    do_tail = 1'b1;
                end else begin
                    step_bl    = r_group_bits;
                    step_phase = vlid_pkg::PH_GROUP;
                end
            end
        endcase
    end

    // single increment adder and overflow tracking
    always_comb begin
        sum_w   = {1'b0, (use_shift ? sh_acc : r_acc)} + (VW+1)'(addend);
        acc_new = add_en ? sum_w[VW-1:0] : (use_shift ? sh_acc : r_acc);
        ovf_new = r_ovf || set_ovf || (use_shift && r_acc[VW-1]) ||
                  (add_en && sum_w[VW]);
    end

    // value completes after the tail, or at once when the tail is empty
    always_comb begin
        do_emit = 1'b0;
        n_phase = step_phase;
        n_zc    = step_zc;
        n_bl    = step_bl;
        n_acc   = acc_new;
        n_ovf   = ovf_new;
        if (r_phase == vlid_pkg::PH_TAIL && bl_dec == '0) begin
            do_emit = 1'b1;
        end else if (do_tail) begin
            if (r_tail_bits == '0) begin
                do_emit = 1'b1;
            end else begin
                n_bl    = r_tail_bits;
                n_phase = vlid_pkg::PH_TAIL;
            end
        end
        if (do_emit) begin
            n_phase = vlid_pkg::PH_PREFIX;
            n_acc   = '0;
            n_zc    = '0;
            n_bl    = '0;
            n_ovf   = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_bits <= vlid_pkg::BL_WIDTH'(1);
            r_tail_bits  <= '0;
            r_classic    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vlid_pkg::CFG_GROUP_BITS:   r_group_bits <= i_cfg_data;
                vlid_pkg::CFG_TAIL_BITS:    r_tail_bits  <= i_cfg_data;
                vlid_pkg::CFG_CLASSIC_MODE: r_classic    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vlid_pkg::PH_PREFIX;
            r_acc   <= '0;
            r_zc    <= '0;
            r_bl    <= '0;
            r_ovf   <= 1'b0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_zc    <= n_zc;
            r_bl    <= n_bl;
            r_ovf   <= n_ovf;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= do_emit;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && do_emit) begin
            r_out_value <= vlid_pkg::OUT_WIDTH'(acc_new);
            r_out_ovf   <= ovf_new;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_decoded_value = r_out_value;
    assign o_overflow      = r_out_ovf;

endmodule

`default_nettype wire
